@@ design/atan2_pkg.sv @@
package atan2_pkg;

  localparam int IN_WIDTH   = 16;
  localparam int MAG_W      = IN_WIDTH;
  localparam int REM_W      = MAG_W + 1;
  localparam int Q_W        = 17;
  localparam int T2_W       = 2 * Q_W - 1;
  localparam int P_W        = 36;
  localparam int R_W        = 40;
  localparam int X_W        = 80;
  localparam int POLY_TERMS = 8;
  localparam int COEF_SLOTS = 12;
  localparam int START      = COEF_SLOTS - POLY_TERMS;
  localparam int ANGLE_W    = 16;
  localparam int ANGLE_MAX  = 25736;

  localparam logic signed [R_W-1:0] PI_Q32  = 40'sd13493037705;
  localparam logic signed [R_W-1:0] PIH_Q32 = 40'sd6746518852;

  typedef struct packed {
    logic zero;
    logic swap;
    logic xneg;
    logic yneg;
  } side_t;

  function automatic logic signed [P_W-1:0] coef_at(input int i);
    logic signed [P_W-1:0] c;
    case (i)
      4:       c = 36'sd12463497;
      5:       c = -36'sd69968176;
      6:       c = 36'sd185038432;
      7:       c = -36'sd323878688;
      8:       c = 36'sd457863808;
      9:       c = -36'sd610296768;
      10:      c = 36'sd858717696;
      11:      c = -36'sd1431647616;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [X_W-1:0] rnd_sh(input logic signed [X_W-1:0] v,
                                                   input int sh);
    logic signed [X_W-1:0] half;
    half = X_W'(1) <<< (sh - 1);
    if (v >= 0) begin
      return (v + half) >>> sh;
    end
    return -((-v + half) >>> sh);
  endfunction

endpackage

@@ design/atan2_div_cell.sv @@
module atan2_div_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       valid_in,
  input  logic [atan2_pkg::REM_W-1:0] rem_in,
  input  logic [atan2_pkg::MAG_W-1:0] mx_in,
  input  logic [atan2_pkg::Q_W-1:0]   q_in,
  input  atan2_pkg::side_t            side_in,
  output logic                       valid_out,
  output logic [atan2_pkg::REM_W-1:0] rem_out,
  output logic [atan2_pkg::MAG_W-1:0] mx_out,
  output logic [atan2_pkg::Q_W-1:0]   q_out,
  output atan2_pkg::side_t            side_out
);
  import atan2_pkg::*;

  logic             d;
  logic [REM_W-1:0] r;

  always_comb begin
    d = rem_in >= {1'b0, mx_in};
    r = d ? rem_in - {1'b0, mx_in} : rem_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= {r[REM_W-2:0], 1'b0};
      mx_out   <= mx_in;
      q_out    <= {q_in[Q_W-2:0], d};
      side_out <= side_in;
    end
  end

endmodule

@@ design/atan2_horner_cell.sv @@
module atan2_horner_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              valid_in,
  input  logic signed [atan2_pkg::P_W-1:0]  p_in,
  input  logic [atan2_pkg::T2_W-1:0]        t2_in,
  input  logic [atan2_pkg::Q_W-1:0]         q_in,
  input  atan2_pkg::side_t                  side_in,
  input  logic signed [atan2_pkg::P_W-1:0]  coef,
  output logic                              valid_out,
  output logic signed [atan2_pkg::P_W-1:0]  p_out,
  output logic [atan2_pkg::T2_W-1:0]        t2_out,
  output logic [atan2_pkg::Q_W-1:0]         q_out,
  output atan2_pkg::side_t                  side_out
);
  import atan2_pkg::*;

  logic signed [X_W-1:0] prod;
  logic signed [P_W-1:0] p_next;

  always_comb begin
    prod   = X_W'(p_in) * X_W'($signed({1'b0, t2_in}));
    p_next = P_W'(rnd_sh(prod, 32)) + coef;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_out    <= p_next;
      t2_out   <= t2_in;
      q_out    <= q_in;
      side_out <= side_in;
    end
  end

endmodule

@@ design/atan2_poly_approx.sv @@
// Registers in order: input, divider cells, Horner input, Horner cells, product, angle.
// Throughput: one transaction per cycle unless stalled; a 17-cell divider chain and
// a chain of POLY_TERMS Horner cells, each one multiply per cell, advance together.
// A stall on a valid output holds the whole chain and stalls the input.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
module atan2_poly_approx (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [atan2_pkg::IN_WIDTH-1:0]    x_val,
  input  logic signed [atan2_pkg::IN_WIDTH-1:0]    y_val,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [atan2_pkg::ANGLE_W-1:0]     angle
);
  import atan2_pkg::*;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic [MAG_W-1:0] ax, ay;
  side_t            side0;
  always_comb begin
    ax = x_val[IN_WIDTH-1] ? MAG_W'(-x_val) : MAG_W'(x_val);
    ay = y_val[IN_WIDTH-1] ? MAG_W'(-y_val) : MAG_W'(y_val);
    side0.swap = ax <= ay;
    side0.zero = (ax == '0) && (ay == '0);
    side0.xneg = x_val[IN_WIDTH-1] || (x_val == '0);
    side0.yneg = y_val[IN_WIDTH-1];
  end

  logic             dv   [Q_W+1];
  logic [REM_W-1:0] drem [Q_W+1];
  logic [MAG_W-1:0] dmx  [Q_W+1];
  logic [Q_W-1:0]   dq   [Q_W+1];
  side_t            dside[Q_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drem[0]  <= {1'b0, (side0.swap ? ax : ay)};
      dmx[0]   <= side0.swap ? ay : ax;
      dq[0]    <= '0;
      dside[0] <= side0;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    atan2_div_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .valid_in(dv[k]), .rem_in(drem[k]), .mx_in(dmx[k]), .q_in(dq[k]),
      .side_in(dside[k]),
      .valid_out(dv[k+1]), .rem_out(drem[k+1]), .mx_out(dmx[k+1]),
      .q_out(dq[k+1]), .side_out(dside[k+1])
    );
  end

  logic                  hv   [POLY_TERMS+1];
  logic signed [P_W-1:0] hp   [POLY_TERMS+1];
  logic [T2_W-1:0]       ht2  [POLY_TERMS+1];
  logic [Q_W-1:0]        hq   [POLY_TERMS+1];
  side_t                 hside[POLY_TERMS+1];
  logic [2*Q_W-1:0]      sq;

  assign sq = dq[Q_W] * dq[Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      hv[0] <= 1'b0;
    end else if (en) begin
      hv[0] <= dv[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hp[0]    <= coef_at(START);
      ht2[0]   <= sq[T2_W-1:0];
      hq[0]    <= dq[Q_W];
      hside[0] <= dside[Q_W];
    end
  end

  for (genvar k = 0; k < POLY_TERMS; k++) begin : g_horner
    localparam logic signed [P_W-1:0] C = (k < POLY_TERMS - 1) ? coef_at(START + 1 + k) : '0;
    atan2_horner_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .valid_in(hv[k]), .p_in(hp[k]), .t2_in(ht2[k]), .q_in(hq[k]),
      .side_in(hside[k]), .coef(C),
      .valid_out(hv[k+1]), .p_out(hp[k+1]), .t2_out(ht2[k+1]),
      .q_out(hq[k+1]), .side_out(hside[k+1])
    );
  end

  logic signed [X_W-1:0] mprod;
  logic signed [R_W-1:0] r_next;
  logic signed [R_W-1:0] r;
  side_t                 mside;
  logic                  mv;

  always_comb begin
    mprod  = X_W'(hp[POLY_TERMS]) * X_W'($signed({1'b0, hq[POLY_TERMS]}));
    r_next = R_W'(rnd_sh(mprod, 16)) + $signed(R_W'({hq[POLY_TERMS], 16'b0}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (en) begin
      mv <= hv[POLY_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r     <= r_next;
      mside <= hside[POLY_TERMS];
    end
  end

  logic signed [R_W-1:0] r1, r2, r3;
  logic signed [X_W-1:0] a;
  logic signed [ANGLE_W-1:0] angle_next;

  always_comb begin
    r1 = mside.swap ? PIH_Q32 - r : r;
    r2 = mside.xneg ? PI_Q32 - r1 : r1;
    r3 = mside.yneg ? -r2 : r2;
    a  = rnd_sh(X_W'(r3), 19);
    if (mside.zero) begin
      angle_next = '0;
    end else if (a > X_W'(ANGLE_MAX)) begin
      angle_next = ANGLE_W'(ANGLE_MAX);
    end else if (a < -X_W'(ANGLE_MAX)) begin
      angle_next = -ANGLE_W'(ANGLE_MAX);
    end else begin
      angle_next = ANGLE_W'(a);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= angle_next;
    end
  end

endmodule

@@ design/atan2_checker.sv @@
module atan2_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic signed [atan2_pkg::IN_WIDTH-1:0] x_val,
  input logic signed [atan2_pkg::IN_WIDTH-1:0] y_val,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [atan2_pkg::ANGLE_W-1:0]  angle
);
  import atan2_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(angle))
    else $error("output transaction dropped or changed under stall");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(x_val) && $stable(y_val))
    else $error("input transaction dropped or changed under stall");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle <= ANGLE_W'(ANGLE_MAX)) && (angle >= -ANGLE_W'(ANGLE_MAX)))
    else $error("angle out of range");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind atan2_poly_approx atan2_checker u_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .x_val(x_val), .y_val(y_val), .out_valid(out_valid), .out_stall(out_stall),
  .angle(angle)
);
